[sv/iiee_pkg.sv]
package iiee_pkg;

    localparam int VALUE_W     = 32;
    localparam int MAX_NESTING = 16;
    localparam int NEST_W      = 5;
    localparam int STK_AW      = 4;
    localparam int CNT_W       = 6;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    typedef enum logic [1:0] {
        MD_NONE = 2'd0,
        MD_MUL  = 2'd1,
        MD_DIV  = 2'd2
    } muldiv_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DIV0   = 2'd1,
        ST_NEST   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIN,
        S_MUL,
        S_DIV,
        S_DIVFIX,
        S_POST,
        S_POP,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        K_ADD,
        K_MULDIV,
        K_CLOSE,
        K_LAST
    } kind_t;

endpackage

[sv/infix_integer_expression_evaluator_core.sv]
// infix integer expression evaluator
// s_axis: one ascii character per request, tdata = ch, tlast marks the end
// of the expression. m_axis: one result per expression on the last request,
// tdata = {status[1:0], value[31:0]} from the lowest bit up, value first.
// digits, '(' and ignored characters are taken in the idle state alone;
// so is ')' at a bad level. '+', '-', '*' and '/' pass through finish and
// post, and ')' through finish, post and pop, with no pending * or /.
// a last character adds finish, sum and output steps to its own work.
// a pending '*' adds a shift-add multiplier, one bit per cycle.
// a pending '/' adds a restoring divider, one bit per cycle, plus
// a sign fix step. the longest item is a last ')' that closes a division
// and then finishes an outer division.
// s_tready is low while an item is being worked on and while a result
// waits in the output register for m_tready; a stalled receiver thus holds
// the whole block. the nesting stack is a 16 entry memory of saved sums,
// terms and ops; it needs no clearing since an entry is read only after
// it has been pushed. after aresetn the evaluation state is zero (not the
// datapath registers) and s_tready is high once the output register is
// empty. after each result the evaluation state returns to reset values.
module infix_integer_expression_evaluator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic [39:0] m_tdata,   // value[31:0], status[33:32], zero fill
    output logic        m_tvalid,
    input  logic        m_tready
);
    import iiee_pkg::*;

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   sum_reg, sum_next;
    logic [VALUE_W-1:0]   term_reg, term_next;
    logic                 neg_reg, neg_next;
    muldiv_t              md_reg, md_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    status_t              err_reg, err_next;
    logic [NEST_W-1:0]    lvl_reg, lvl_next;
    kind_t                kind_reg, kind_next;
    logic                 minus_reg, minus_next;
    logic                 mul_sel_reg, mul_sel_next;
    logic                 last_reg, last_next;
    logic [VALUE_W-1:0]   a_reg, a_next;
    logic [VALUE_W-1:0]   b_reg, b_next;
    logic [VALUE_W-1:0]   p_reg, p_next;
    logic [VALUE_W-1:0]   rem_reg, rem_next;
    logic                 qneg_reg, qneg_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   x_reg, x_next;
    logic                 mv_reg, mv_next;
    logic [VALUE_W+1:0]   mdata_reg, mdata_next;

    logic [VALUE_W-1:0]   stk_sum [MAX_NESTING];
    logic [VALUE_W-1:0]   stk_term [MAX_NESTING];
    logic [2:0]           stk_op [MAX_NESTING];
    logic [VALUE_W-1:0]   rd_sum_reg, rd_term_reg;
    logic [2:0]           rd_op_reg;
    logic                 push;
    logic [STK_AW-1:0]    push_addr, pop_addr;

    logic                 acc_in;
    logic [7:0]           ch;
    logic [VALUE_W:0]     trial;
    logic [VALUE_W-1:0]   tval, lvl_val;

    assign ch       = s_tdata;
    assign acc_in   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'd0, mdata_reg};
    assign push_addr = lvl_reg[STK_AW-1:0];
    assign pop_addr  = lvl_reg[STK_AW-1:0] - 1'b1;
    assign trial    = {rem_reg, a_reg[VALUE_W-1]} - {1'b0, b_reg};
    assign tval     = neg_reg ? (~x_reg + 1'b1) : x_reg;
    assign lvl_val  = sum_reg + tval;

    always_ff @(posedge aclk) begin
        if (push) begin
            stk_sum[push_addr]  <= sum_reg;
            stk_term[push_addr] <= term_reg;
            stk_op[push_addr]   <= {neg_reg, md_reg};
        end
        rd_sum_reg  <= stk_sum[pop_addr];
        rd_term_reg <= stk_term[pop_addr];
        rd_op_reg   <= stk_op[pop_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sum_reg   <= '0;
            term_reg  <= '0;
            neg_reg   <= 1'b0;
            md_reg    <= MD_NONE;
            acc_reg   <= '0;
            err_reg   <= ST_OK;
            lvl_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            term_reg  <= term_next;
            neg_reg   <= neg_next;
            md_reg    <= md_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
            lvl_reg   <= lvl_next;
            mv_reg    <= mv_next;
        end
        kind_reg    <= kind_next;
        minus_reg   <= minus_next;
        mul_sel_reg <= mul_sel_next;
        last_reg    <= last_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        p_reg       <= p_next;
        rem_reg     <= rem_next;
        qneg_reg    <= qneg_next;
        cnt_reg     <= cnt_next;
        x_reg       <= x_next;
        mdata_reg   <= mdata_next;
    end

    always_comb begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        term_next    = term_reg;
        neg_next     = neg_reg;
        md_next      = md_reg;
        acc_next     = acc_reg;
        err_next     = err_reg;
        lvl_next     = lvl_reg;
        kind_next    = kind_reg;
        minus_next   = minus_reg;
        mul_sel_next = mul_sel_reg;
        last_next    = last_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        p_next       = p_reg;
        rem_next     = rem_reg;
        qneg_next    = qneg_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        mv_next      = mv_reg;
        mdata_next   = mdata_reg;
        push         = 1'b0;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (acc_in) begin
                    minus_next   = (ch == CH_MINUS);
                    mul_sel_next = (ch == CH_MUL);
                    last_next    = s_tlast;
                    kind_next    = K_LAST;
                    if (ch >= CH_0 && ch <= CH_9) begin
                        acc_next = (acc_reg << 3) + (acc_reg << 1)
                                 + {{(VALUE_W-4){1'b0}}, 4'(ch - CH_0)};
                    end else if (ch == CH_PLUS || ch == CH_MINUS) begin
                        kind_next = K_ADD;
                    end else if (ch == CH_MUL || ch == CH_DIV) begin
                        kind_next = K_MULDIV;
                    end else if (ch == CH_OPEN) begin
                        if (lvl_reg >= NEST_W'(MAX_NESTING)) begin
                            if (err_reg == ST_OK) err_next = ST_NEST;
                        end else begin
                            push      = 1'b1;
                            lvl_next  = lvl_reg + 1'b1;
                            sum_next  = '0;
                            term_next = '0;
                            neg_next  = 1'b0;
                            md_next   = MD_NONE;
                            acc_next  = '0;
                        end
                    end else if (ch == CH_CLOSE) begin
                        if (lvl_reg == '0 || lvl_reg > NEST_W'(MAX_NESTING)) begin
                            if (err_reg == ST_OK) err_next = ST_NEST;
                        end else begin
                            kind_next = K_CLOSE;
                        end
                    end
                    if (kind_next != K_LAST || s_tlast) begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN: begin
                a_next   = term_reg;
                b_next   = acc_reg;
                p_next   = '0;
                cnt_next = '0;
                x_next   = acc_reg;
                acc_next = '0;
                if (md_reg == MD_MUL) begin
                    state_next = S_MUL;
                end else if (md_reg == MD_DIV) begin
                    qneg_next = term_reg[VALUE_W-1] ^ acc_reg[VALUE_W-1];
                    a_next = term_reg[VALUE_W-1] ? ~term_reg + 1'b1 : term_reg;
                    b_next = acc_reg[VALUE_W-1] ? ~acc_reg + 1'b1 : acc_reg;
                    rem_next = '0;
                    if (acc_reg == '0) begin
                        if (err_reg == ST_OK) err_next = ST_DIV0;
                        x_next     = '0;
                        state_next = S_POST;
                    end else begin
                        state_next = S_DIV;
                    end
                end else begin
                    state_next = S_POST;
                end
                md_next = MD_NONE;
            end
            S_MUL: begin
                if (b_reg[0]) p_next = p_reg + a_reg;
                a_next   = a_reg << 1;
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W-1)) begin
                    x_next     = b_reg[0] ? p_reg + a_reg : p_reg;
                    state_next = S_POST;
                end
            end
            S_DIV: begin
                if (!trial[VALUE_W]) begin
                    rem_next = trial[VALUE_W-1:0];
                end else begin
                    rem_next = {rem_reg[VALUE_W-2:0], a_reg[VALUE_W-1]};
                end
                a_next   = {a_reg[VALUE_W-2:0], !trial[VALUE_W]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W-1)) state_next = S_DIVFIX;
            end
            S_DIVFIX: begin
                x_next     = qneg_reg ? ~a_reg + 1'b1 : a_reg;
                state_next = S_POST;
            end
            S_POST: begin
                case (kind_reg)
                    K_ADD: begin
                        sum_next = lvl_val;
                        neg_next = minus_reg;
                        if (last_reg) begin
                            kind_next  = K_LAST;
                            state_next = S_FIN;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                    K_MULDIV: begin
                        term_next = x_reg;
                        md_next   = mul_sel_reg ? MD_MUL : MD_DIV;
                        if (last_reg) begin
                            kind_next  = K_LAST;
                            state_next = S_FIN;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                    K_CLOSE: begin
                        acc_next   = lvl_val;
                        lvl_next   = lvl_reg - 1'b1;
                        state_next = S_POP;
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_POP: begin
                sum_next  = rd_sum_reg;
                term_next = rd_term_reg;
                md_next   = muldiv_t'(rd_op_reg[1:0]);
                neg_next  = rd_op_reg[2];
                if (last_reg) begin
                    kind_next  = K_LAST;
                    state_next = S_FIN;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (!mv_reg) begin
                    mv_next = 1'b1;
                    if (err_reg != ST_OK || lvl_reg != '0) begin
                        mdata_next = {(err_reg != ST_OK ? err_reg : ST_NEST),
                                      {VALUE_W{1'b0}}};
                    end else begin
                        mdata_next = {ST_OK, lvl_val};
                    end
                    sum_next   = '0;
                    term_next  = '0;
                    neg_next   = 1'b0;
                    md_next    = MD_NONE;
                    acc_next   = '0;
                    err_next   = ST_OK;
                    lvl_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_nest_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lvl_reg <= NEST_W'(MAX_NESTING))
        else $error("nesting level beyond stack depth");
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("ready while busy");
    a_err_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33:32] != ST_OK) |-> (m_tdata[31:0] == '0))
        else $error("error result with nonzero value");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");
`endif

endmodule
